// File: design/focs_pkg.sv
package focs_pkg;

    // fixed formats
    localparam int UDC_W = 15;
    localparam int PER_W = 16;
    localparam int CMP_W = 16;
    localparam int TRIG_W = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // reset values of the configuration registers
    localparam logic [UDC_W-1:0] BUS_VOLTAGE_RST = 15'd16384;
    localparam logic [PER_W-1:0] PWM_PERIOD_RST = 16'd1000;

    // register index, taken from paddr[2]
    localparam logic REG_BUS_VOLTAGE = 1'b0;
    localparam logic REG_PWM_PERIOD = 1'b1;

    // 1/sqrt3 and sqrt3/2 in Q16
    localparam int INV_SQRT3_Q16 = 37837;
    localparam int HALF_SQRT3_Q16 = 56755;

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    // divider: remainder width, quotient width, two quotient bits per cycle
    localparam int REM_W = 33;
    localparam int QUO_W = 18;
    localparam int DEN_W = 32;
    localparam int DIV_STEPS = QUO_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // per phase entry in the queue: zero flag, saturate flag, remainder seed
    localparam int PH_W = REM_W + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_div_state;

    // first quadrant sine in q15, u in units of 1/(2^dlog * 4) turn, u <= 2^dlog
    function automatic logic [TRIG_W-1:0] sine_quarter(input longint unsigned u,
                                                       input int unsigned dlog);
        longint unsigned r;
        longint unsigned r2;
        longint unsigned h;
        longint unsigned s;
        r = (u * TWO_PI_Q30) >> (dlog + 2);
        r2 = (r * r) >> 30;
        h = ONE_Q30 - r2 / 110;
        h = ONE_Q30 - ((r2 * h) >> 30) / 72;
        h = ONE_Q30 - ((r2 * h) >> 30) / 42;
        h = ONE_Q30 - ((r2 * h) >> 30) / 20;
        h = ONE_Q30 - ((r2 * h) >> 30) / 6;
        s = (r * h) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[TRIG_W-1:0];
    endfunction

endpackage

// File: design/focs_in_if.sv
interface focs_in_if #(
    parameter int DATA_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] phase_a_current;
    logic signed [DATA_WIDTH-1:0] phase_b_current;
    logic signed [DATA_WIDTH-1:0] phase_c_current;
    logic signed [DATA_WIDTH-1:0] d_voltage;
    logic signed [DATA_WIDTH-1:0] q_voltage;
    logic [ANGLE_WIDTH-1:0]       rotor_angle;

    modport source (
        output valid, phase_a_current, phase_b_current, phase_c_current,
        output d_voltage, q_voltage, rotor_angle,
        input ready
    );

    modport sink (
        input valid, phase_a_current, phase_b_current, phase_c_current,
        input d_voltage, q_voltage, rotor_angle,
        output ready
    );
endinterface

// File: design/focs_out_if.sv
interface focs_out_if #(
    parameter int DATA_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [DATA_WIDTH-1:0]   d_current;
    logic signed [DATA_WIDTH-1:0]   q_current;
    logic [focs_pkg::CMP_W-1:0]     compare_a;
    logic [focs_pkg::CMP_W-1:0]     compare_b;
    logic [focs_pkg::CMP_W-1:0]     compare_c;

    modport source (
        output valid, d_current, q_current, compare_a, compare_b, compare_c,
        input ready
    );

    modport sink (
        input valid, d_current, q_current, compare_a, compare_b, compare_c,
        output ready
    );
endinterface

// File: design/foc_transforms_and_svpwm_core.sv
// FOC transform engine: each transaction carries three phase currents, the d/q voltage
// commands and the rotor angle, and returns id/iq (Clarke then Park, saturated) and
// three PWM compare counts (inverse Park, inverse Clarke, min-max zero sequence
// injection, scaled by pwm_period over bus_voltage and clamped to 0..pwm_period).
// An 8-stage front pipeline does the table lookup and multiplies and feeds a
// 2-entry queue; the back end runs a 2-bit-per-cycle divider for the three compares,
// one transaction at a time, while the queue holds the next ones. SINE_TABLE_DEPTH
// must be a power of two; a bus_voltage of 0 acts as 1. Registers: bus_voltage at
// address 0, pwm_period at address 4; the user must see that they are written only
// while no transaction is in flight, which the block does not enforce.
module foc_transforms_and_svpwm_core #(
    parameter int DATA_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    focs_in_if.sink                           i_in,
    focs_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [focs_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [focs_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [focs_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    localparam int QW = 2 * DATA_WIDTH + 3 * focs_pkg::PH_W;

    logic [focs_pkg::UDC_W-1:0] r_bus_voltage;
    logic [focs_pkg::PER_W-1:0] r_pwm_period;
    logic [focs_pkg::UDC_W-1:0] w_udc;
    logic                       w_wr;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_voltage <= focs_pkg::BUS_VOLTAGE_RST;
            r_pwm_period <= focs_pkg::PWM_PERIOD_RST;
        end else if (w_wr) begin
            case (paddr[2])
                focs_pkg::REG_BUS_VOLTAGE: r_bus_voltage <= pwdata[focs_pkg::UDC_W-1:0];
                focs_pkg::REG_PWM_PERIOD: r_pwm_period <= pwdata[focs_pkg::PER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            focs_pkg::REG_BUS_VOLTAGE: prdata = focs_pkg::CFG_DATA_W'(r_bus_voltage);
            focs_pkg::REG_PWM_PERIOD: prdata = focs_pkg::CFG_DATA_W'(r_pwm_period);
            default: prdata = '0;
        endcase
    end

    // zero bus voltage divides as one
    assign w_udc = (r_bus_voltage == '0) ? focs_pkg::UDC_W'(1) : r_bus_voltage;

    logic          w_f_vld, w_f_rdy;
    logic [QW-1:0] w_f_data;
    logic          w_b_vld, w_b_rdy;
    logic [QW-1:0] w_b_data;

    focs_front #(
        .DATA_WIDTH       (DATA_WIDTH),
        .ANGLE_WIDTH      (ANGLE_WIDTH),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_in.valid),
        .o_ready           (i_in.ready),
        .i_phase_a_current (i_in.phase_a_current),
        .i_phase_b_current (i_in.phase_b_current),
        .i_phase_c_current (i_in.phase_c_current),
        .i_d_voltage       (i_in.d_voltage),
        .i_q_voltage       (i_in.q_voltage),
        .i_rotor_angle     (i_in.rotor_angle),
        .i_udc             (w_udc),
        .i_period          (r_pwm_period),
        .o_valid           (w_f_vld),
        .i_ready           (w_f_rdy),
        .o_data            (w_f_data)
    );

    focs_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_vld),
        .o_ready (w_f_rdy),
        .i_data  (w_f_data),
        .o_valid (w_b_vld),
        .i_ready (w_b_rdy),
        .o_data  (w_b_data)
    );

    focs_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_b_vld),
        .o_ready     (w_b_rdy),
        .i_data      (w_b_data),
        .i_udc       (w_udc),
        .i_period    (r_pwm_period),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_d_current (o_out.d_current),
        .o_q_current (o_out.q_current),
        .o_compare_a (o_out.compare_a),
        .o_compare_b (o_out.compare_b),
        .o_compare_c (o_out.compare_c)
    );

endmodule

// File: design/focs_front.sv
module focs_front #(
    parameter int DATA_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [DATA_WIDTH-1:0]        i_phase_a_current,
    input  logic signed [DATA_WIDTH-1:0]        i_phase_b_current,
    input  logic signed [DATA_WIDTH-1:0]        i_phase_c_current,
    input  logic signed [DATA_WIDTH-1:0]        i_d_voltage,
    input  logic signed [DATA_WIDTH-1:0]        i_q_voltage,
    input  logic [ANGLE_WIDTH-1:0]              i_rotor_angle,
    input  logic [focs_pkg::UDC_W-1:0]          i_udc,
    input  logic [focs_pkg::PER_W-1:0]          i_period,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [2*DATA_WIDTH+3*focs_pkg::PH_W-1:0] o_data
);
    localparam int DW = DATA_WIDTH;
    localparam int TW_TRIG = focs_pkg::TRIG_W;
    localparam int DLOG = $clog2(SINE_TABLE_DEPTH);
    localparam int QN = SINE_TABLE_DEPTH / 4 + 1;
    localparam int MW = DLOG - 1;
    localparam int PBW = DW + 19;
    localparam int BW = DW + 2;
    localparam int CPW = DW + TW_TRIG;
    localparam int BPW = BW + TW_TRIG;
    localparam int SW = BPW + 1;
    localparam int UW = DW + 2;
    localparam int PVW = UW + 18;
    localparam int VW = DW + 20;
    localparam int TW = VW + 2;
    localparam int EW = ((TW > 31) ? TW : 31) + 1;
    localparam int NW = EW + focs_pkg::PER_W + 1;
    localparam int XW = NW - 17;
    localparam int CW = (XW > focs_pkg::REM_W) ? XW : focs_pkg::REM_W;
    localparam int RW = focs_pkg::REM_W;
    localparam int NS = 8;
    localparam logic [MW:0] HALF_D = (MW+1)'(SINE_TABLE_DEPTH / 2);
    localparam logic [MW-1:0] QUART_D = MW'(SINE_TABLE_DEPTH / 4);

    function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
        logic ok;
        ok = (&v[SW-1:DW-1]) || !(|v[SW-1:DW-1]);
        return ok ? v[DW-1:0] : {v[SW-1], {(DW-1){~v[SW-1]}}};
    endfunction

    logic [NS-1:0] r_vld;
    logic          w_en;

    // quarter wave sine table
    logic [TW_TRIG-1:0] w_lut [QN];
    for (genvar k = 0; k < QN; k++) begin : g_lut
        assign w_lut[k] = focs_pkg::sine_quarter(64'(4 * k), DLOG);
    end

    logic [DLOG-1:0] w_idx;
    if (DLOG == ANGLE_WIDTH) begin : g_idx_eq
        assign w_idx = i_rotor_angle;
    end else if (DLOG > ANGLE_WIDTH) begin : g_idx_up
        assign w_idx = {i_rotor_angle, {(DLOG-ANGLE_WIDTH){1'b0}}};
    end else begin : g_idx_dn
        assign w_idx = i_rotor_angle[ANGLE_WIDTH-1 -: DLOG];
    end

    // lane 0 sine, lane 1 cosine (a quarter turn later)
    logic [DLOG-1:0]              w_ph   [2];
    logic signed [TW_TRIG-1:0]    w_trig [2];
    assign w_ph[0] = w_idx;
    assign w_ph[1] = w_idx + DLOG'(SINE_TABLE_DEPTH / 4);

    for (genvar l = 0; l < 2; l++) begin : g_fold
        logic [MW-1:0]      w_half;
        logic [MW-1:0]      w_m;
        logic [TW_TRIG-1:0] w_mag;
        assign w_half = w_ph[l][MW-1:0];
        assign w_m = (w_half > QUART_D) ? MW'(HALF_D - {1'b0, w_half}) : w_half;
        assign w_mag = w_lut[w_m];
        assign w_trig[l] = w_ph[l][DLOG-1] ? -signed'(w_mag) : signed'(w_mag);
    end

    // stage 1
    logic signed [DW:0]       w_dif;
    logic signed [PBW-1:0]    w_bp;
    logic signed [DW-1:0]     r1_ia, r1_ud, r1_uq;
    logic signed [TW_TRIG-1:0] r1_sn, r1_cs;
    logic signed [PBW-1:0]    r1_bp;
    assign w_dif = (DW+1)'(i_phase_b_current) - (DW+1)'(i_phase_c_current);
    assign w_bp = w_dif * $signed(18'(focs_pkg::INV_SQRT3_Q16));

    // stage 2
    logic signed [BW-1:0]  w_beta;
    logic signed [CPW-1:0] w_ac, w_as, w_dc, w_qs, w_ds, w_qc;
    logic signed [BPW-1:0] w_bs, w_bc;
    logic signed [CPW-1:0] r2_ac, r2_as, r2_dc, r2_qs, r2_ds, r2_qc;
    logic signed [BPW-1:0] r2_bs, r2_bc;
    assign w_beta = BW'((r1_bp + PBW'(32768)) >>> 16);
    assign w_ac = r1_ia * r1_cs;
    assign w_as = r1_ia * r1_sn;
    assign w_dc = r1_ud * r1_cs;
    assign w_qs = r1_uq * r1_sn;
    assign w_ds = r1_ud * r1_sn;
    assign w_qc = r1_uq * r1_cs;
    assign w_bs = w_beta * r1_sn;
    assign w_bc = w_beta * r1_cs;

    // stage 3
    logic signed [SW-1:0] w_id_s, w_iq_s, w_ua_s, w_ub_s;
    logic signed [UW-1:0] r3_ual, r3_ubt;
    assign w_id_s = (SW'(r2_ac) + SW'(r2_bs) + SW'(16384)) >>> 15;
    assign w_iq_s = (SW'(r2_bc) - SW'(r2_as) + SW'(16384)) >>> 15;
    assign w_ua_s = (SW'(r2_dc) - SW'(r2_qs) + SW'(16384)) >>> 15;
    assign w_ub_s = (SW'(r2_ds) + SW'(r2_qc) + SW'(16384)) >>> 15;

    // stage 4
    logic signed [PVW-1:0] w_pb;
    logic signed [UW-1:0]  r4_ual;
    logic signed [PVW-1:0] r4_pb;
    assign w_pb = r3_ubt * $signed(18'(focs_pkg::HALF_SQRT3_Q16));

    // stage 5: phase voltages, scaled by 65536
    logic signed [VW-1:0] w_ua;
    logic signed [VW-1:0] r5_v [3];
    assign w_ua = VW'(r4_ual);

    // stage 6: centered, doubled
    logic signed [VW-1:0] w_mx, w_mn;
    logic signed [VW:0]   w_sum;
    logic signed [TW-1:0] r6_t [3];
    always_comb begin
        w_mx = (r5_v[0] > r5_v[1]) ? r5_v[0] : r5_v[1];
        if (r5_v[2] > w_mx) begin
            w_mx = r5_v[2];
        end
        w_mn = (r5_v[0] < r5_v[1]) ? r5_v[0] : r5_v[1];
        if (r5_v[2] < w_mn) begin
            w_mn = r5_v[2];
        end
    end
    assign w_sum = (VW+1)'(w_mx) + (VW+1)'(w_mn);

    // stage 7 and 8: numerator, then divider seed
    logic signed [EW-1:0] w_udc16;
    logic signed [NW-1:0] w_udc16n;
    logic [CW-1:0]        w_udc18;
    logic signed [NW-1:0] r7_num [3];
    logic                 r8_zero [3];
    logic                 r8_sat [3];
    logic [RW-1:0]        r8_rem [3];
    assign w_udc16 = EW'(signed'({1'b0, i_udc, 16'b0}));
    assign w_udc16n = NW'(w_udc16);
    assign w_udc18 = CW'({i_udc, 18'b0});

    logic signed [EW-1:0] w_e   [3];
    logic signed [NW-1:0] w_num [3];
    logic signed [NW-1:0] w_n   [3];
    logic [XW-1:0]        w_x   [3];
    for (genvar p = 0; p < 3; p++) begin : g_ph
        assign w_e[p] = w_udc16 - EW'(r6_t[p]);
        assign w_num[p] = w_e[p] * signed'({1'b0, i_period});
        assign w_n[p] = r7_num[p] + w_udc16n;
        assign w_x[p] = w_n[p][NW-1:17];
    end

    // id and iq travel alongside
    logic signed [DW-1:0] r_id [3:NS];
    logic signed [DW-1:0] r_iq [3:NS];

    assign w_en = !r_vld[NS-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ia <= i_phase_a_current;
            r1_ud <= i_d_voltage;
            r1_uq <= i_q_voltage;
            r1_sn <= w_trig[0];
            r1_cs <= w_trig[1];
            r1_bp <= w_bp;

            r2_ac <= w_ac;
            r2_as <= w_as;
            r2_dc <= w_dc;
            r2_qs <= w_qs;
            r2_ds <= w_ds;
            r2_qc <= w_qc;
            r2_bs <= w_bs;
            r2_bc <= w_bc;

            r_id[3] <= sat_dw(w_id_s);
            r_iq[3] <= sat_dw(w_iq_s);
            r3_ual <= UW'(w_ua_s);
            r3_ubt <= UW'(w_ub_s);

            r4_ual <= r3_ual;
            r4_pb <= w_pb;

            r5_v[0] <= w_ua <<< 16;
            r5_v[1] <= -(w_ua <<< 15) + VW'(r4_pb);
            r5_v[2] <= -(w_ua <<< 15) - VW'(r4_pb);

            for (int p = 0; p < 3; p++) begin
                r6_t[p] <= (TW'(r5_v[p]) <<< 1) - TW'(w_sum);
                r7_num[p] <= w_num[p];
                r8_zero[p] <= r7_num[p][NW-1] || (r7_num[p] == '0);
                r8_sat[p] <= CW'(w_x[p]) >= w_udc18;
                r8_rem[p] <= RW'(CW'(w_x[p]));
            end

            for (int s = 4; s <= NS; s++) begin
                r_id[s] <= r_id[s-1];
                r_iq[s] <= r_iq[s-1];
            end
        end
    end

    assign o_data = {r_id[NS], r_iq[NS],
                     r8_zero[0], r8_sat[0], r8_rem[0],
                     r8_zero[1], r8_sat[1], r8_rem[1],
                     r8_zero[2], r8_sat[2], r8_rem[2]};

endmodule

// File: design/focs_queue.sv
module focs_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0]                r_mem [focs_pkg::QUEUE_DEPTH];
    logic [focs_pkg::QPTR_W-1:0]     r_wp;
    logic [focs_pkg::QPTR_W-1:0]     r_rp;
    logic [focs_pkg::QCNT_W-1:0]     r_cnt;
    logic                            w_push;
    logic                            w_pop;

    assign o_ready = (r_cnt != focs_pkg::QCNT_W'(focs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: design/focs_back.sv
module focs_back #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [2*DATA_WIDTH+3*focs_pkg::PH_W-1:0] i_data,
    input  logic [focs_pkg::UDC_W-1:0]               i_udc,
    input  logic [focs_pkg::PER_W-1:0]               i_period,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic signed [DATA_WIDTH-1:0]             o_d_current,
    output logic signed [DATA_WIDTH-1:0]             o_q_current,
    output logic [focs_pkg::CMP_W-1:0]               o_compare_a,
    output logic [focs_pkg::CMP_W-1:0]               o_compare_b,
    output logic [focs_pkg::CMP_W-1:0]               o_compare_c
);
    localparam int DW = DATA_WIDTH;
    localparam int QW = 2 * DW + 3 * focs_pkg::PH_W;
    localparam int RW = focs_pkg::REM_W;
    localparam int PW = focs_pkg::PH_W;
    localparam int QUW = focs_pkg::QUO_W;
    localparam int CW = focs_pkg::CMP_W;
    localparam logic [focs_pkg::DIV_CNT_W-1:0] LAST =
        focs_pkg::DIV_CNT_W'(focs_pkg::DIV_STEPS - 1);

    focs_pkg::t_div_state r_state, n_state;
    logic [focs_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [focs_pkg::DEN_W-1:0]     r_d;
    logic [RW-1:0]                  r_rem  [3];
    logic [QUW-1:0]                 r_quo  [3];
    logic                           r_zero [3];
    logic                           r_sat  [3];
    logic signed [DW-1:0]           r_id, r_iq;

    logic                           r_out_vld;
    logic signed [DW-1:0]           r_out_id, r_out_iq;
    logic [CW-1:0]                  r_out_cmp [3];

    logic                           w_pop;
    logic                           w_load;

    // two restoring steps per cycle, shared divisor for all three phases
    logic [RW-1:0]  w_d1, w_d0;
    logic           w_ge1 [3];
    logic           w_ge0 [3];
    logic [RW-1:0]  w_r1  [3];
    logic [RW-1:0]  w_r2  [3];
    logic [CW-1:0]  w_cmp [3];
    assign w_d1 = RW'(r_d);
    assign w_d0 = w_d1 >> 1;

    for (genvar p = 0; p < 3; p++) begin : g_lane
        assign w_ge1[p] = r_rem[p] >= w_d1;
        assign w_r1[p] = w_ge1[p] ? r_rem[p] - w_d1 : r_rem[p];
        assign w_ge0[p] = w_r1[p] >= w_d0;
        assign w_r2[p] = w_ge0[p] ? w_r1[p] - w_d0 : w_r1[p];
        assign w_cmp[p] = r_zero[p] ? '0 :
                          (r_sat[p] || (r_quo[p] > QUW'(i_period))) ? i_period :
                          r_quo[p][CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= focs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_pop = 1'b0;
        w_load = 1'b0;
        case (r_state)
            focs_pkg::S_IDLE: begin
                w_pop = i_valid;
                if (i_valid) begin
                    n_state = focs_pkg::S_DIV;
                end
            end
            focs_pkg::S_DIV: begin
                if (r_cnt == LAST) begin
                    n_state = focs_pkg::S_DONE;
                end
            end
            focs_pkg::S_DONE: begin
                if (!r_out_vld || i_ready) begin
                    w_load = 1'b1;
                    w_pop = i_valid;
                    n_state = i_valid ? focs_pkg::S_DIV : focs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = focs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_pop) begin
            r_cnt <= '0;
        end else if (r_state == focs_pkg::S_DIV) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_d <= focs_pkg::DEN_W'({i_udc, 17'b0});
            r_id <= i_data[QW-1 -: DW];
            r_iq <= i_data[QW-DW-1 -: DW];
            for (int p = 0; p < 3; p++) begin
                r_zero[p] <= i_data[(2-p)*PW + PW - 1];
                r_sat[p] <= i_data[(2-p)*PW + PW - 2];
                r_rem[p] <= i_data[(2-p)*PW +: RW];
                r_quo[p] <= '0;
            end
        end else if (r_state == focs_pkg::S_DIV) begin
            r_d <= r_d >> 2;
            for (int p = 0; p < 3; p++) begin
                r_rem[p] <= w_r2[p];
                r_quo[p] <= {r_quo[p][QUW-3:0], w_ge1[p], w_ge0[p]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_id <= r_id;
            r_out_iq <= r_iq;
            for (int p = 0; p < 3; p++) begin
                r_out_cmp[p] <= w_cmp[p];
            end
        end
    end

    assign o_ready = w_pop;
    assign o_valid = r_out_vld;
    assign o_d_current = r_out_id;
    assign o_q_current = r_out_iq;
    assign o_compare_a = r_out_cmp[0];
    assign o_compare_b = r_out_cmp[1];
    assign o_compare_c = r_out_cmp[2];

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == focs_pkg::S_DIV && r_cnt == LAST) |=> r_state == focs_pkg::S_DONE)
        else $error("divider did not finish after its last step");

    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_state == focs_pkg::S_DIV && r_cnt == '0))
        else $error("queue pop did not start a division");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_out_vld)
        else $error("loaded result not presented");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == focs_pkg::S_DONE && r_out_vld && !i_ready) |=>
        r_state == focs_pkg::S_DONE)
        else $error("finished result dropped while output stalled");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic signed [15:0] ia;
        logic signed [15:0] ib;
        logic signed [15:0] ic;
        logic signed [15:0] ud;
        logic signed [15:0] uq;
        logic [15:0]        ang;
    } t_foc_in;

    typedef struct packed {
        logic signed [15:0] id;
        logic signed [15:0] iq;
        logic [15:0]        cmp_a;
        logic [15:0]        cmp_b;
        logic [15:0]        cmp_c;
    } t_foc_out;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [focs_pkg::CFG_ADDR_W-1:0] paddr;
    logic [focs_pkg::CFG_DATA_W-1:0] pwdata;
    logic [focs_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;

    focs_in_if #(.DATA_WIDTH(16), .ANGLE_WIDTH(16)) in_if ();
    focs_out_if #(.DATA_WIDTH(16)) out_if ();

    foc_transforms_and_svpwm_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the registers
    logic [14:0] bus_v;
    logic [15:0] period;

    t_foc_in  pending_q[$];
    t_foc_out expected_q[$];

    int n_items, n_results, n_errors, idle_cyc;
    logic src_pause;
    logic hold_go, hold_done;
    int gap_left, burst_left, hold_left, rx_mode, rx_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // sine in q15 of a phase given in units of 1/4096 turn
    function automatic longint table_sine(longint unsigned ph);
        longint unsigned r, r2, h, s;
        logic neg;
        neg = 1'b0;
        if (ph >= 2048) begin
            neg = 1'b1;
            ph = ph - 2048;
        end
        if (ph > 1024) ph = 2048 - ph;
        r = (ph * 64'd6746518852) / 4096;
        r2 = (r * r) >> 30;
        h = 64'd1073741824 - r2 / 110;
        h = 64'd1073741824 - ((r2 * h) >> 30) / 72;
        h = 64'd1073741824 - ((r2 * h) >> 30) / 42;
        h = 64'd1073741824 - ((r2 * h) >> 30) / 20;
        h = 64'd1073741824 - ((r2 * h) >> 30) / 6;
        s = (r * h) >> 30;
        s = (s + 16384) >> 15;
        if (s > 32767) s = 32767;
        return neg ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp16(longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic logic [15:0] duty_count(longint t, longint udc, longint per);
        longint num, den, q;
        num = per * (udc * 65536 - t);
        den = udc * 131072;
        if (num <= 0) return 16'd0;
        q = (num + den / 2) / den;
        if (q > per) q = per;
        return q[15:0];
    endfunction

    function automatic t_foc_out foc_predict(t_foc_in it);
        t_foc_out o;
        longint unsigned ph;
        longint sn, cs, beta, ual, ubt, va, vb, vc, mx, mn, udc, per;
        ph = 4 * ((longint'(it.ang) * 1024) >> 16);
        sn = table_sine(ph);
        cs = table_sine((ph + 1024) % 4096);
        beta = round_shift((longint'(it.ib) - longint'(it.ic)) * 37837, 16);
        o.id = 16'(clamp16(round_shift(longint'(it.ia) * cs + beta * sn, 15)));
        o.iq = 16'(clamp16(round_shift(beta * cs - longint'(it.ia) * sn, 15)));
        ual = round_shift(longint'(it.ud) * cs - longint'(it.uq) * sn, 15);
        ubt = round_shift(longint'(it.ud) * sn + longint'(it.uq) * cs, 15);
        va = ual * 65536;
        vb = -ual * 32768 + ubt * 56755;
        vc = -ual * 32768 - ubt * 56755;
        mx = va > vb ? va : vb;
        if (vc > mx) mx = vc;
        mn = va < vb ? va : vb;
        if (vc < mn) mn = vc;
        udc = (bus_v == 0) ? 1 : longint'(bus_v);
        per = longint'(period);
        o.cmp_a = duty_count(2 * va - (mx + mn), udc, per);
        o.cmp_b = duty_count(2 * vb - (mx + mn), udc, per);
        o.cmp_c = duty_count(2 * vc - (mx + mn), udc, per);
        return o;
    endfunction

    function automatic logic [15:0] pick_word(int mode);
        int sel;
        sel = $urandom_range(0, 5);
        if (mode == 0) return 16'($urandom);
        if (mode == 1) return 16'($urandom_range(0, 2047)) - 16'd1024;
        case (sel)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_foc_in random_item();
        t_foc_in it;
        int mode;
        mode = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2);
        it.ia = pick_word(mode);
        it.ib = pick_word(mode);
        it.ic = pick_word(mode);
        it.ud = pick_word(mode);
        it.uq = pick_word(mode);
        it.ang = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 7) * 8192) : 16'($urandom);
        return it;
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_q.push_back(foc_predict({in_if.phase_a_current, in_if.phase_b_current,
                    in_if.phase_c_current, in_if.d_voltage, in_if.q_voltage,
                    in_if.rotor_angle}));
                n_items++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_if.valid <= 1'b0;
                end else if (pending_q.size() > 0 && !src_pause) begin
                    t_foc_in nx;
                    nx = pending_q.pop_front();
                    in_if.phase_a_current <= nx.ia;
                    in_if.phase_b_current <= nx.ib;
                    in_if.phase_c_current <= nx.ic;
                    in_if.d_voltage <= nx.ud;
                    in_if.q_voltage <= nx.uq;
                    in_if.rotor_angle <= nx.ang;
                    in_if.valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern by mode, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
            rx_mode <= 0;
            rx_left <= 0;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_if.ready <= (hold_left == 1);
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 2);
                rx_left <= $urandom_range(20, 200);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= $urandom_range(0, 1);
                default: out_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cyc <= 0;
            else idle_cyc <= idle_cyc + 1;
            if (idle_cyc > 5000) begin
                $display("watchdog: no transaction for %0d cycles", idle_cyc);
                $display("Mismatches found");
                $finish;
            end
            if (out_if.valid && out_if.ready) begin
                t_foc_out got, want;
                got = {out_if.d_current, out_if.q_current, out_if.compare_a,
                       out_if.compare_b, out_if.compare_c};
                n_results++;
                if (expected_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("result %0d: id %0d/%0d iq %0d/%0d cmp %0d,%0d,%0d/%0d,%0d,%0d",
                                n_results, got.id, want.id, got.iq, want.iq, got.cmp_a,
                                got.cmp_b, got.cmp_c, want.cmp_a, want.cmp_b, want.cmp_c);
                    end
                end
            end
        end
    end

    task automatic reg_write(logic addr_bit, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {addr_bit, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr_bit == focs_pkg::REG_BUS_VOLTAGE) bus_v = val[14:0];
        else period = val[15:0];
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || in_if.valid || expected_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic push_dir(int ia, int ib, int ic, int ud, int uq, int ang);
        t_foc_in it;
        it.ia = 16'(ia); it.ib = 16'(ib); it.ic = 16'(ic);
        it.ud = 16'(ud); it.uq = 16'(uq); it.ang = 16'(ang);
        pending_q.push_back(it);
    endtask

    int unsigned bus_set[7] = '{16384, 1, 32767, 0, 20000, 32767, 100};
    int unsigned per_set[7] = '{1000, 65535, 1, 500, 0, 65535, 3000};

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        src_pause = 1'b0; hold_go = 1'b0;
        n_items = 0; n_results = 0; n_errors = 0; idle_cyc = 0;
        in_if.valid = 1'b0;
        in_if.phase_a_current = '0; in_if.phase_b_current = '0; in_if.phase_c_current = '0;
        in_if.d_voltage = '0; in_if.q_voltage = '0; in_if.rotor_angle = '0;
        bus_v = focs_pkg::BUS_VOLTAGE_RST;
        period = focs_pkg::PWM_PERIOD_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values first, with the corner items
        push_dir(0, 0, 0, 0, 0, 0);
        push_dir(32767, 32767, -32768, 32767, 32767, 0);
        push_dir(-32768, -32768, 32767, -32768, -32768, 65535);
        push_dir(-32768, -32768, 32767, 0, 0, 8192);
        push_dir(32767, 32767, -32768, 0, 0, 8192);
        push_dir(-32768, 32767, -32768, 32767, -32768, 16384);
        push_dir(32767, -32768, 32767, -32768, 32767, 32768);
        push_dir(1000, -500, -500, 16000, 0, 49152);
        push_dir(0, 0, 0, 32767, 0, 24576);
        push_dir(0, 0, 0, -32768, 32767, 40960);
        push_dir(-1, -1, -1, -1, -1, 63);
        push_dir(12345, -2222, 777, 8000, -8000, 12000);
        for (int k = 0; k < 30; k++) pending_q.push_back(random_item());
        drain();

        for (int p = 0; p < 7; p++) begin
            reg_write(focs_pkg::REG_BUS_VOLTAGE, {$urandom} & 32'hffff8000 | bus_set[p]);
            reg_write(focs_pkg::REG_PWM_PERIOD, {16'($urandom), 16'(per_set[p])});
            if (p == 2) begin
                hold_go <= 1'b1;
                repeat (3) @(posedge i_clk);
            end
            for (int k = 0; k < 65; k++) pending_q.push_back(random_item());
            // sender pause mid phase until the block is empty
            if (p == 4) begin
                while (pending_q.size() > 30) @(posedge i_clk);
                src_pause <= 1'b1;
                while (in_if.valid || expected_q.size() > 0) @(posedge i_clk);
                src_pause <= 1'b0;
            end
            drain();
        end

        $display("covered %0d transactions and %0d results over 8 register settings",
                 n_items, n_results);
        $display("including zero bus voltage, zero period and a long output hold-off");
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d errors, %0d results missing", n_errors, expected_q.size());
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// File: sim.f
design/focs_pkg.sv
design/focs_in_if.sv
design/focs_out_if.sv
design/focs_front.sv
design/focs_queue.sv
design/focs_back.sv
design/foc_transforms_and_svpwm_core.sv
verif/tb_top.sv
